/* rtl/core/rmp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared constants and controller/datapath interface types for the
// reachable maximum propagation block.
// ----------------------------------------------------------------------------
package rmp_pkg;

	// Fixed field widths
	localparam int VERTEX_W = 6;
	localparam int VCNT_W   = 7;
	localparam int CMD_W    = 2;

	// Default parameter values
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 256;
	localparam int DEF_VALUE_BITS   = 16;

	// Largest vertex count a run ever uses
	localparam int VCNT_LIMIT = 64;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EDGE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load_vertex;
		logic add_edge;
		logic pass_start;
		logic edge_read;
		logic vertex_read;
		logic relax;
		logic edge_next;
		logic emit_start;
		logic emit_read;
		logic emit_load;
		logic emit_next;
	} rmp_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic edges_empty;
		logic edge_last;
		logic changed;
		logic emit_last;
		logic out_free;
	} rmp_sts_t;

endpackage
`default_nettype wire

/* rtl/core/reachable_max_propagation_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reachable_max_propagation_core
// Gives every vertex the largest initial value of all vertices reaching it.
// ----------------------------------------------------------------------------
// Load (cmd 0) and add-edge (cmd 1) transfers leave the block ready again the
// next cycle. A run (cmd 2) stalls the input until its last result has been
// loaded into the output register: after a setup state it visits every stored
// edge in each relaxation pass (read the edge table, then read source and
// target from the two-read-port vertex memory, then compare and write back),
// and repeats passes until one changes nothing (at most one pass per vertex in
// use). Results then leave one at a time, each read from the vertex memory and
// then loaded into the output register once it is free of a stalled result.
// Edges whose endpoints lie at or above the vertex count in use are skipped;
// edge_overflow reports edges dropped since reset because the table was full.
// ----------------------------------------------------------------------------
module reachable_max_propagation_core
	import rmp_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES,
	parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         vertex_count_we,
	input  wire logic [VCNT_W-1:0]            vertex_count_wdata,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [CMD_W-1:0]             cmd,
	input  wire logic [VERTEX_W-1:0]          vertex,
	input  wire logic signed [VALUE_BITS-1:0] value,
	input  wire logic [VERTEX_W-1:0]          edge_from,
	input  wire logic [VERTEX_W-1:0]          edge_to,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [VERTEX_W-1:0]               vertex_res,
	output logic signed [VALUE_BITS-1:0]      result_value,
	output logic                              last,
	output logic                              edge_overflow
);

	rmp_ctl_t ctl;
	rmp_sts_t sts;

	// Sequencer
	rmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.ctl      (ctl),
		.sts      (sts)
	);

	// Storage and arithmetic
	rmp_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.VALUE_BITS   (VALUE_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.sts                (sts),
		.vertex             (vertex),
		.value              (value),
		.edge_from          (edge_from),
		.edge_to            (edge_to),
		.vertex_count_we    (vertex_count_we),
		.vertex_count_wdata (vertex_count_wdata),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.vertex_res         (vertex_res),
		.result_value       (result_value),
		.last               (last),
		.edge_overflow      (edge_overflow)
	);

endmodule
`default_nettype wire

/* rtl/core/rmp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_ctrl
// Sequencer: takes commands, runs relaxation passes over the edge table
// until a pass changes nothing, then steps the results out.
// ----------------------------------------------------------------------------
module rmp_ctrl
	import rmp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [CMD_W-1:0] cmd,
	output rmp_ctl_t              ctl,
	input  wire rmp_sts_t         sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_ERD  = 3'd2;
	localparam logic [2:0] ST_VRD  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_ORD  = 3'd5;
	localparam logic [2:0] ST_OLD  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Next state and command decode
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_LOAD: ctl.load_vertex = 1'b1;
						CMD_EDGE: ctl.add_edge = 1'b1;
						CMD_RUN:  state_nxt = ST_RUN;
						default:  ;
					endcase
				end
			end
			ST_RUN: begin
				if (sts.edges_empty) begin
					ctl.emit_start = 1'b1;
					state_nxt      = ST_ORD;
				end else begin
					ctl.pass_start = 1'b1;
					state_nxt      = ST_ERD;
				end
			end
			ST_ERD: begin
				ctl.edge_read = 1'b1;
				state_nxt     = ST_VRD;
			end
			ST_VRD: begin
				ctl.vertex_read = 1'b1;
				state_nxt       = ST_CMP;
			end
			ST_CMP: begin
				ctl.relax = 1'b1;
				if (!sts.edge_last) begin
					ctl.edge_next = 1'b1;
					state_nxt     = ST_ERD;
				end else if (sts.changed) begin
					ctl.pass_start = 1'b1;
					state_nxt      = ST_ERD;
				end else begin
					ctl.emit_start = 1'b1;
					state_nxt      = ST_ORD;
				end
			end
			ST_ORD: begin
				ctl.emit_read = 1'b1;
				state_nxt     = ST_OLD;
			end
			ST_OLD: begin
				if (sts.out_free) begin
					ctl.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_nxt = ST_IDLE;
					end else begin
						ctl.emit_next = 1'b1;
						state_nxt     = ST_ORD;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/rmp_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_datapath
// Vertex value memory, edge table, pass and emit counters, relax compare
// and the result output register.
// ----------------------------------------------------------------------------
module rmp_datapath
	import rmp_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES,
	parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rmp_ctl_t                     ctl,
	output rmp_sts_t                          sts,
	input  wire logic [VERTEX_W-1:0]          vertex,
	input  wire logic signed [VALUE_BITS-1:0] value,
	input  wire logic [VERTEX_W-1:0]          edge_from,
	input  wire logic [VERTEX_W-1:0]          edge_to,
	input  wire logic                         vertex_count_we,
	input  wire logic [VCNT_W-1:0]            vertex_count_wdata,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [VERTEX_W-1:0]               vertex_res,
	output logic signed [VALUE_BITS-1:0]      result_value,
	output logic                              last,
	output logic                              edge_overflow
);

	localparam int VDEPTH  = (MAX_VERTICES < VCNT_LIMIT) ? MAX_VERTICES : VCNT_LIMIT;
	localparam int VIDX_W  = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
	localparam int EIDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
	localparam int EDATA_W = 2 * VERTEX_W;

	// Vertex count register and the count actually used by a run
	logic [VCNT_W-1:0] vcount_q;
	logic [VCNT_W-1:0] n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCNT_W'(1);
		end else if (vertex_count_we) begin
			vcount_q <= vertex_count_wdata;
		end
	end

	always_comb begin
		if (vcount_q == '0) begin
			n_eff = VCNT_W'(1);
		end else if (32'(vcount_q) > 32'(VDEPTH)) begin
			n_eff = VCNT_W'(VDEPTH);
		end else begin
			n_eff = vcount_q;
		end
	end

	// Edge table: append on add, one read per edge visit
	logic [EDATA_W-1:0] edge_mem [MAX_EDGES];
	logic [EDATA_W-1:0] edge_s1;
	logic [ECNT_W-1:0]  edge_total_q;
	logic [EIDX_W-1:0]  edge_idx_q;
	logic               dropped_q;
	logic               edge_full;

	assign edge_full = (edge_total_q == ECNT_W'(MAX_EDGES));

	always_ff @(posedge clk) begin
		if (ctl.add_edge && !edge_full) begin
			edge_mem[edge_total_q[EIDX_W-1:0]] <= {edge_from, edge_to};
		end
		if (ctl.edge_read) begin
			edge_s1 <= edge_mem[edge_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			dropped_q    <= 1'b0;
		end else if (ctl.add_edge) begin
			if (edge_full) begin
				dropped_q <= 1'b1;
			end else begin
				edge_total_q <= edge_total_q + ECNT_W'(1);
			end
		end
	end

	// Edge visit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_idx_q <= '0;
		end else if (ctl.pass_start) begin
			edge_idx_q <= '0;
		end else if (ctl.edge_next) begin
			edge_idx_q <= edge_idx_q + EIDX_W'(1);
		end
	end

	// Edge endpoints and range check
	logic [VERTEX_W-1:0] src;
	logic [VERTEX_W-1:0] tgt;
	logic                edge_ok;

	assign src     = edge_s1[EDATA_W-1:VERTEX_W];
	assign tgt     = edge_s1[VERTEX_W-1:0];
	assign edge_ok = (VCNT_W'(src) < n_eff) && (VCNT_W'(tgt) < n_eff);

	// Emit counter
	logic [VIDX_W-1:0] emit_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
		end else if (ctl.emit_start) begin
			emit_idx_q <= '0;
		end else if (ctl.emit_next) begin
			emit_idx_q <= emit_idx_q + VIDX_W'(1);
		end
	end

	// Vertex value memory: one write port, two registered read ports
	logic signed [VALUE_BITS-1:0] vmem [VDEPTH];
	logic signed [VALUE_BITS-1:0] va_s2;
	logic signed [VALUE_BITS-1:0] vb_s2;
	logic [VIDX_W-1:0]            tgt_s2;
	logic                         ok_s2;
	logic                         hit;
	logic                         load_ok;
	logic                         vwr_en;
	logic [VIDX_W-1:0]            vwr_addr;
	logic signed [VALUE_BITS-1:0] vwr_data;
	logic [VIDX_W-1:0]            rda_addr;

	assign hit     = ok_s2 && (va_s2 > vb_s2);
	assign load_ok = ctl.load_vertex && (32'(vertex) < 32'(MAX_VERTICES));

	always_comb begin
		vwr_en   = 1'b0;
		vwr_addr = vertex[VIDX_W-1:0];
		vwr_data = value;
		if (load_ok) begin
			vwr_en = 1'b1;
		end else if (ctl.relax && hit) begin
			vwr_en   = 1'b1;
			vwr_addr = tgt_s2;
			vwr_data = va_s2;
		end
	end

	assign rda_addr = ctl.emit_read ? emit_idx_q : src[VIDX_W-1:0];

	always_ff @(posedge clk) begin
		if (vwr_en) begin
			vmem[vwr_addr] <= vwr_data;
		end
		if (ctl.vertex_read || ctl.emit_read) begin
			va_s2 <= vmem[rda_addr];
		end
		if (ctl.vertex_read) begin
			vb_s2  <= vmem[tgt[VIDX_W-1:0]];
			tgt_s2 <= tgt[VIDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s2 <= 1'b0;
		end else if (ctl.vertex_read) begin
			ok_s2 <= edge_ok;
		end
	end

	// Pass change flag
	logic changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
		end else if (ctl.pass_start) begin
			changed_q <= 1'b0;
		end else if (ctl.relax && hit) begin
			changed_q <= 1'b1;
		end
	end

	// Output register
	logic                         out_valid_q;
	logic [VERTEX_W-1:0]          vertex_res_q;
	logic signed [VALUE_BITS-1:0] result_q;
	logic                         last_q;
	logic                         overflow_q;
	logic                         emit_last;

	assign emit_last = ((VCNT_W'(emit_idx_q) + VCNT_W'(1)) == n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_load) begin
			vertex_res_q <= VERTEX_W'(emit_idx_q);
			result_q     <= va_s2;
			last_q       <= emit_last;
			overflow_q   <= dropped_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex_res    = vertex_res_q;
	assign result_value  = result_q;
	assign last          = last_q;
	assign edge_overflow = overflow_q;

	// Status to controller
	assign sts.edges_empty = (edge_total_q == '0);
	assign sts.edge_last   = ((ECNT_W'(edge_idx_q) + ECNT_W'(1)) == edge_total_q);
	assign sts.changed     = changed_q || (ctl.relax && hit);
	assign sts.emit_last   = emit_last;
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

/* rtl/core/rmp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_checker
// Port-level checks on command timing and result ordering.
// ----------------------------------------------------------------------------
module rmp_checker
	import rmp_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic [CMD_W-1:0]             cmd,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [VERTEX_W-1:0]          vertex_res,
	input wire logic signed [VALUE_BITS-1:0] result_value,
	input wire logic                         last,
	input wire logic                         edge_overflow
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vertex_res)
			&& $stable(result_value) && $stable(last) && $stable(edge_overflow))
		else $error("stalled result changed");

	// A run occupies the block
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_RUN |=> in_stall)
		else $error("run transfer did not stall input");

	// Loads and edge adds leave the input unstalled the next cycle
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_LOAD || cmd == CMD_EDGE) |=> !in_stall)
		else $error("load or edge transfer stalled input");

	// Input stays stalled while a run still has results to give
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken in the middle of a run");

	// Overflow flag is sticky across results
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_overflow |=> !out_valid || edge_overflow)
		else $error("edge_overflow cleared");

endmodule

bind reachable_max_propagation_core rmp_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_rmp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.cmd           (cmd),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.vertex_res    (vertex_res),
	.result_value  (result_value),
	.last          (last),
	.edge_overflow (edge_overflow)
);
`default_nettype wire

/* tb/sv/reachable_max_propagation_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reachable_max_propagation_checker
// Watches the command, configuration and result channels of the reachable
// maximum propagation core, keeps its own copy of the vertex values and the
// edge table, works out the per-vertex results of every run and compares
// each result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module reachable_max_propagation_checker
	import rmp_pkg::*;
(
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           vertex_count_we,
	input  wire logic [VCNT_W-1:0]              vertex_count_wdata,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic [CMD_W-1:0]               cmd,
	input  wire logic [VERTEX_W-1:0]            vertex,
	input  wire logic signed [DEF_VALUE_BITS-1:0] value,
	input  wire logic [VERTEX_W-1:0]            edge_from,
	input  wire logic [VERTEX_W-1:0]            edge_to,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic [VERTEX_W-1:0]            vertex_res,
	input  wire logic signed [DEF_VALUE_BITS-1:0] result_value,
	input  wire logic                           last,
	input  wire logic                           edge_overflow,
	output int                                  fail_count,
	output int                                  results_pending,
	output int                                  results_checked
);

	// One predicted result transfer
	typedef struct packed {
		logic [VERTEX_W-1:0]               vertex;
		logic signed [DEF_VALUE_BITS-1:0]  value;
		logic                              last;
		logic                              overflow;
	} vertex_result_t;

	// Shadow copy of the block state
	logic signed [DEF_VALUE_BITS-1:0] vertex_vals [DEF_MAX_VERTICES];
	logic [VERTEX_W-1:0]              edge_src [DEF_MAX_EDGES];
	logic [VERTEX_W-1:0]              edge_dst [DEF_MAX_EDGES];
	int                               edge_cnt = 0;
	logic                             table_dropped = 1'b0;
	logic [VCNT_W-1:0]                count_reg = 7'd1;
	vertex_result_t                   results_q [$];

	initial begin
		fail_count      = 0;
		results_pending = 0;
		results_checked = 0;
	end

	// Predict on every accepted transfer; blocking updates, read only by the
	// top at the falling edge or at the end of the run
	always @(posedge clk or negedge arst_n) begin : predict
		int             n;
		int             i;
		int             s;
		int             t;
		bit             changed;
		vertex_result_t want;
		if (!arst_n) begin
			count_reg     = 7'd1;
			edge_cnt      = 0;
			table_dropped = 1'b0;
			results_q.delete();
			results_pending = 0;
		end else begin
			// result transfer: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				if (results_q.size() == 0) begin
					$error("unexpected result transfer: vertex_res %0d result_value %0d",
						vertex_res, result_value);
					fail_count++;
				end else begin
					want = results_q.pop_front();
					results_checked++;
					if (vertex_res !== want.vertex) begin
						$error("vertex_res mismatch: expected %0d, actual %0d",
							want.vertex, vertex_res);
						fail_count++;
					end
					if (result_value !== want.value) begin
						$error("result_value mismatch: expected %0d, actual %0d",
							$signed(want.value), result_value);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last mismatch: expected %0b, actual %0b", want.last, last);
						fail_count++;
					end
					if (edge_overflow !== want.overflow) begin
						$error("edge_overflow mismatch: expected %0b, actual %0b",
							want.overflow, edge_overflow);
						fail_count++;
					end
				end
			end

			// register write
			if (vertex_count_we)
				count_reg = vertex_count_wdata;

			// command transfer
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_LOAD: vertex_vals[vertex] = value;
					CMD_EDGE: begin
						if (edge_cnt >= DEF_MAX_EDGES) begin
							table_dropped = 1'b1;
						end else begin
							edge_src[edge_cnt] = edge_from;
							edge_dst[edge_cnt] = edge_to;
							edge_cnt++;
						end
					end
					CMD_RUN: begin
						// zero means one; anything past the limit saturates
						n = (count_reg == 0) ? 1 :
							(count_reg > VCNT_LIMIT) ? VCNT_LIMIT : int'(count_reg);
						// relax edges until a full pass changes nothing
						do begin
							changed = 1'b0;
							for (i = 0; i < edge_cnt; i++) begin
								s = int'(edge_src[i]);
								t = int'(edge_dst[i]);
								if (s < n && t < n && vertex_vals[s] > vertex_vals[t]) begin
									vertex_vals[t] = vertex_vals[s];
									changed = 1'b1;
								end
							end
						end while (changed);
						for (i = 0; i < n; i++) begin
							want.vertex   = i[VERTEX_W-1:0];
							want.value    = vertex_vals[i];
							want.last     = (i == n - 1);
							want.overflow = table_dropped;
							results_q     = {results_q, want};
						end
					end
					default: ; // unused code: no effect
				endcase
			end
			results_pending = results_q.size();
		end
	end

endmodule

/* tb/sv/reachable_max_propagation_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reachable_max_propagation_core_tb
// Drives loads, edges, runs and unused commands into the core under random
// input gaps and result back-pressure, across several vertex-count settings
// including the out-of-range ones, and fills the edge table past its end.
// A checker beside the core predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module reachable_max_propagation_core_tb;
	import rmp_pkg::*;

	localparam int WATCHDOG_LIMIT = 250000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 60;
	localparam int PHASE_ITEMS    = 24;

	// code the core ignores
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              vertex_count_we = 1'b0;
	logic [VCNT_W-1:0]                 vertex_count_wdata = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [CMD_W-1:0]                  cmd = CMD_LOAD;
	logic [VERTEX_W-1:0]               vertex = '0;
	logic signed [DEF_VALUE_BITS-1:0]  value = '0;
	logic [VERTEX_W-1:0]               edge_from = '0;
	logic [VERTEX_W-1:0]               edge_to = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [VERTEX_W-1:0]               vertex_res;
	logic signed [DEF_VALUE_BITS-1:0]  result_value;
	logic                              last;
	logic                              edge_overflow;

	int fail_count;
	int results_pending;
	int results_checked;

	// Stimulus bookkeeping
	bit loaded [DEF_MAX_VERTICES] = '{default: 1'b0};
	int active_n = 1;
	int transfers = 0;
	int edges_sent = 0;
	int runs_sent = 0;
	int settings = 0;
	bit gaps_off = 1'b0;
	int quiet_cycles = 0;
	int stall_hold = 0;

	always #10 clk = ~clk;

	reachable_max_propagation_core u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.vertex_count_we    (vertex_count_we),
		.vertex_count_wdata (vertex_count_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.cmd                (cmd),
		.vertex             (vertex),
		.value              (value),
		.edge_from          (edge_from),
		.edge_to            (edge_to),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.vertex_res         (vertex_res),
		.result_value       (result_value),
		.last               (last),
		.edge_overflow      (edge_overflow)
	);

	reachable_max_propagation_checker u_chk (
		.clk                (clk),
		.arst_n             (arst_n),
		.vertex_count_we    (vertex_count_we),
		.vertex_count_wdata (vertex_count_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.cmd                (cmd),
		.vertex             (vertex),
		.value              (value),
		.edge_from          (edge_from),
		.edge_to            (edge_to),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.vertex_res         (vertex_res),
		.result_value       (result_value),
		.last               (last),
		.edge_overflow      (edge_overflow),
		.fail_count         (fail_count),
		.results_pending    (results_pending),
		.results_checked    (results_checked)
	);

	// Result back-pressure: mostly short bursts, some long free or stalled stretches
	always @(posedge clk) begin : stall_gen
		int r;
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			r = $urandom_range(99);
			if (r < 55) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(4);
			end else if (r < 65) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(150, 30);
			end else if (r < 92) begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(2);
			end else if (r < 98) begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(10, 3);
			end else begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(60, 20);
			end
		end
	end

	// Watchdog: cycles without any transfer or register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || vertex_count_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Vertex value with a bias toward the extremes
	function automatic logic signed [DEF_VALUE_BITS-1:0] pick_value();
		int r;
		r = $urandom_range(9);
		case (r)
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'hffff;
			default: return DEF_VALUE_BITS'($urandom);
		endcase
	endfunction

	// One command transfer, preceded by a random gap unless gaps are off;
	// field arguments are cut to the port widths
	task automatic send(input logic [CMD_W-1:0] c, input int v, input int val,
			input int ef, input int et);
		int gap;
		int r;
		gap = 0;
		if (!gaps_off) begin
			r = $urandom_range(99);
			if (r >= 97)
				gap = $urandom_range(40, 20);
			else if (r >= 90)
				gap = $urandom_range(10, 4);
			else if (r >= 60)
				gap = $urandom_range(3, 1);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		vertex    <= VERTEX_W'(v);
		value     <= DEF_VALUE_BITS'(val);
		edge_from <= VERTEX_W'(ef);
		edge_to   <= VERTEX_W'(et);
		do @(posedge clk); while (in_stall);
		transfers++;
		case (c)
			CMD_LOAD: loaded[VERTEX_W'(v)] = 1'b1;
			CMD_EDGE: edges_sent++;
			CMD_RUN:  runs_sent++;
			default:  ;
		endcase
	endtask

	// Run command; every vertex in use gets a value first
	task automatic run_graph();
		int v;
		for (v = 0; v < active_n; v++)
			if (!loaded[v])
				send(CMD_LOAD, v, pick_value(), $urandom, $urandom);
		send(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Register write once all results are out and the core has settled
	task automatic set_count(input logic [VCNT_W-1:0] c);
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		vertex_count_we    <= 1'b1;
		vertex_count_wdata <= c;
		@(posedge clk);
		vertex_count_we <= 1'b0;
		active_n = (c == 0) ? 1 : (c > VCNT_LIMIT) ? VCNT_LIMIT : int'(c);
		settings++;
	endtask

	// Stimulus
	initial begin : stimulus
		logic [VCNT_W-1:0] phase_counts [8];
		int a;
		int b;
		int ph;
		int k;
		int r;
		phase_counts = '{7'd127, 7'd2, 7'd64, 7'd5, 7'd33, 7'd1, 7'd64, 7'd20};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex at reset count, most negative value
		send(CMD_LOAD, 0, 16'sh8000, $urandom, $urandom);
		run_graph();
		// zero count acts as one
		set_count(7'd0);
		run_graph();

		// eight vertices, chain entered backwards so each pass moves one hop
		set_count(7'd8);
		send(CMD_LOAD, 0, 16'sh7fff, $urandom, $urandom);
		send(CMD_LOAD, 1, 16'sh8000, $urandom, $urandom);
		send(CMD_LOAD, 2, 16'shffff, $urandom, $urandom);
		send(CMD_LOAD, 3, 16'sh0000, $urandom, $urandom);
		send(CMD_LOAD, 4, 100, $urandom, $urandom);
		send(CMD_LOAD, 5, -200, $urandom, $urandom);
		send(CMD_LOAD, 6, 1, $urandom, $urandom);
		send(CMD_LOAD, 7, 16'sh8000, $urandom, $urandom);
		// stored beyond the count in use
		send(CMD_LOAD, 63, 16'sh7fff, $urandom, $urandom);
		for (k = 6; k >= 0; k--)
			send(CMD_EDGE, $urandom, $urandom, k, k + 1);
		// endpoint beyond the count: stored, skipped by the run
		send(CMD_EDGE, $urandom, $urandom, 63, 0);
		// unused command code
		send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
		run_graph();

		// random phases, one vertex count each
		for (ph = 0; ph < 8; ph++) begin
			set_count(phase_counts[ph]);
			gaps_off = ($urandom_range(3) == 0);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(99);
				if (r < 55) begin
					if ($urandom_range(99) < 85) begin
						a = $urandom_range(active_n - 1);
						b = $urandom_range(active_n - 1);
					end else begin
						a = $urandom;
						b = $urandom;
					end
					send(CMD_EDGE, $urandom, $urandom, a, b);
				end else if (r < 90) begin
					a = ($urandom_range(99) < 80) ? $urandom_range(active_n - 1) : $urandom;
					send(CMD_LOAD, a, pick_value(), $urandom, $urandom);
				end else if (r < 95) begin
					run_graph();
				end else begin
					send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
				end
			end
			// last phase pushes the edge table past full
			if (ph == 7)
				while (edges_sent < DEF_MAX_EDGES + 6)
					send(CMD_EDGE, $urandom, $urandom,
						$urandom_range(active_n - 1), $urandom_range(active_n - 1));
			run_graph();
		end

		// drain
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d command transfers (%0d runs, %0d edges) over %0d count settings",
			transfers, runs_sent, edges_sent, settings + 1);
		$display("Checked %0d vertex results; edge table overflow %s",
			results_checked, (edges_sent > DEF_MAX_EDGES) ? "reached" : "not reached");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
